/* src/tsrq_pkg.sv */
package tsrq_pkg;

    // Field widths fixed by the interface
    localparam int STAMP_W       = 64;
    localparam int LAG_W         = 9;
    localparam int STATUS_W      = 2;
    localparam int OVR_W         = 2;
    localparam int DEPTH_DEFAULT = 32;

    // Configuration register indexes
    localparam logic [0:0] CFG_CORRECTION = 1'd0;
    localparam logic [0:0] CFG_OVERRIDE   = 1'd1;

    // Field order override codes
    localparam logic [OVR_W-1:0] OVR_TOP    = 2'd1;
    localparam logic [OVR_W-1:0] OVR_BOTTOM = 2'd2;

    // Picture status codes
    localparam logic [STATUS_W-1:0] STATUS_PARTIAL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd2;

    // Word kinds
    localparam logic MODE_RESYNC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_INS_LAST,
        ST_POP_CHK,
        ST_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                      frame_out;
        logic                      whole_picture;
        logic signed [STAMP_W-1:0] stamp_out;
        logic                      stamp_out_valid;
        logic                      top_first_out;
        logic                      overflow;
        logic                      no_stamp_error;
    } result_t;

endpackage

/* src/tsrq_mem.sv */
module tsrq_mem
    import tsrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [STAMP_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [STAMP_W-1:0] rdata
);

    logic [STAMP_W-1:0] mem [DEPTH];
    logic [STAMP_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tsrq_ctrl.sv */
module tsrq_ctrl
    import tsrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic signed [STAMP_W-1:0] stamp,
    input  logic                      stamp_valid,
    input  logic [STATUS_W-1:0]       picture_status,
    input  logic                      drop,
    input  logic signed [LAG_W-1:0]   decoder_lag,
    input  logic                      top_first_in,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [OVR_W-1:0]          cfg_data,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [STAMP_W-1:0]        mem_wdata,
    output logic                      mem_re,
    output logic [AW-1:0]             mem_raddr,
    input  logic [STAMP_W-1:0]        mem_rdata,
    output logic                      res_valid,
    input  logic                      res_take,
    output result_t                   res
);

    localparam int CMPW = (CW > 8) ? CW + 1 : 9;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             j_reg, j_next;
    logic                      corr_reg;
    logic [OVR_W-1:0]          ovr_reg;

    logic                      mode_reg;
    logic signed [STAMP_W-1:0] stamp_reg;
    logic                      sv_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic                      drop_reg;
    logic signed [LAG_W-1:0]   lag_reg;
    logic                      top_reg;

    logic                      ovf_reg, ovf_next;
    logic                      nos_reg, nos_next;
    logic [STAMP_W-1:0]        sout_reg, sout_next;
    logic                      sok_reg, sok_next;

    logic                      accept;
    logic                      got_pic;
    logic                      deliver;
    logic                      resync;
    logic                      lag_known;
    logic [CMPW-1:0]           lag_ext;
    logic [CMPW-1:0]           cnt_ext;
    logic                      below_lag;
    logic                      do_insert;
    logic                      full;
    logic [CW-1:0]             cut_cnt;
    logic [CW-1:0]             cnt_m1;
    logic [CW-1:0]             j_m1;
    logic [CW-1:0]             j_m2;
    logic                      top_sel;

    assign accept = in_valid && in_ready;

    // Decode the held word
    assign resync    = (mode_reg == MODE_RESYNC);
    assign got_pic   = (status_reg != STATUS_PARTIAL);
    assign deliver   = (status_reg == STATUS_COMPLETE) && !drop_reg;
    assign lag_known = !lag_reg[LAG_W-1];
    assign lag_ext   = CMPW'(lag_reg[LAG_W-2:0]);
    assign cnt_ext   = CMPW'(count_reg);
    assign below_lag = lag_known && (cnt_ext < lag_ext);
    assign do_insert = corr_reg && sv_reg && (got_pic || below_lag);
    assign full      = (count_reg == CW'(DEPTH));
    assign cnt_m1    = count_reg - CW'(1);
    assign j_m1      = j_reg - CW'(1);
    assign j_m2      = j_reg - CW'(2);

    // Cut the count down to a known lag that does not exceed it
    assign cut_cnt = (lag_known && (lag_ext <= cnt_ext)) ?
                     CW'(lag_reg[LAG_W-2:0]) : count_reg;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg <= 1'b0;
            ovr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CORRECTION: corr_reg <= cfg_data[0];
                CFG_OVERRIDE:   ovr_reg  <= cfg_data;
                default:        ovr_reg  <= ovr_reg;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            stamp_reg  <= stamp;
            sv_reg     <= stamp_valid;
            status_reg <= picture_status;
            drop_reg   <= drop;
            lag_reg    <= decoder_lag;
            top_reg    <= top_first_in;
        end
    end

    // Sequencer state, count and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            j_reg     <= '0;
            ovf_reg   <= 1'b0;
            nos_reg   <= 1'b0;
            sout_reg  <= '0;
            sok_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            j_reg     <= j_next;
            ovf_reg   <= ovf_next;
            nos_reg   <= nos_next;
            sout_reg  <= sout_next;
            sok_reg   <= sok_next;
        end
    end

    // Insert by walking down from the top, then pop the smallest stamp
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg;
        nos_next   = nos_reg;
        sout_next  = sout_reg;
        sok_next   = sok_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = j_reg[AW-1:0];
        mem_wdata  = stamp_reg;
        mem_re     = 1'b0;
        mem_raddr  = j_m1[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ovf_next   = 1'b0;
                    nos_next   = 1'b0;
                    sout_next  = '0;
                    sok_next   = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                j_next = count_reg;
                if (resync)
                begin
                    count_next = '0;
                    state_next = ST_DONE;
                end
                else if (do_insert && full)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_POP_CHK;
                end
                else if (do_insert)
                begin
                    count_next = count_reg + CW'(1);
                    if (count_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        state_next = ST_POP_CHK;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = cnt_m1[AW-1:0];
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_POP_CHK;
                end
            end
            ST_SCAN:
            begin
                mem_we = 1'b1;
                if ($signed(mem_rdata) < stamp_reg)
                begin
                    // move the smaller entry up one place
                    mem_wdata = mem_rdata;
                    j_next    = j_m1;
                    if (j_reg == CW'(1))
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = j_m2[AW-1:0];
                    end
                end
                else
                begin
                    state_next = ST_POP_CHK;
                end
            end
            ST_INS_LAST:
            begin
                mem_we     = 1'b1;
                state_next = ST_POP_CHK;
            end
            ST_POP_CHK:
            begin
                if (deliver && corr_reg)
                begin
                    if (count_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = cnt_m1[AW-1:0];
                        count_next = cnt_m1;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        nos_next   = 1'b1;
                        count_next = cut_cnt;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                sout_next  = mem_rdata;
                sok_next   = 1'b1;
                count_next = cut_cnt;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Apply the field order override
    always_comb
    begin
        case (ovr_reg)
            OVR_TOP:    top_sel = 1'b1;
            OVR_BOTTOM: top_sel = 1'b0;
            default:    top_sel = top_reg;
        endcase
    end

    // Assemble the result word
    always_comb
    begin
        res.frame_out       = !resync && deliver;
        res.whole_picture   = !resync && got_pic;
        res.stamp_out       = sout_reg;
        res.stamp_out_valid = sok_reg;
        res.top_first_out   = !resync && deliver && top_sel;
        res.overflow        = ovf_reg;
        res.no_stamp_error  = nos_reg;
    end

endmodule

/* src/timestamp_reorder_queue_top.sv */
// Timestamp reorder queue: packet timestamps are held in a single-port-write,
// single-port-read memory of DEPTH entries, sorted in descending order with the
// smallest at the top, and are handed back in ascending order to delivered
// frames. Words are processed one at a time: a start state, where a stamp for an
// empty store is written, a read-compare-write walk down through the memory for a
// non-empty store (one entry per cycle through the registered read port), a pop
// check, a pop state when a stamp is popped for a delivered frame, and a done
// state that hands the result to the output register and returns to idle. The
// result sits in an output register, so the next word is taken while it waits.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
module timestamp_reorder_queue_top
    import tsrq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic signed [STAMP_W-1:0] stamp,
    input  logic                      stamp_valid,
    input  logic [STATUS_W-1:0]       picture_status,
    input  logic                      drop,
    input  logic signed [LAG_W-1:0]   decoder_lag,
    input  logic                      top_first_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      frame_out,
    output logic                      whole_picture,
    output logic signed [STAMP_W-1:0] stamp_out,
    output logic                      stamp_out_valid,
    output logic                      top_first_out,
    output logic                      overflow,
    output logic                      no_stamp_error,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [OVR_W-1:0]          cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [STAMP_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [STAMP_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_take;
    result_t            res;
    result_t            res_reg;
    logic               out_valid_reg;

    tsrq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tsrq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .stamp          (stamp),
        .stamp_valid    (stamp_valid),
        .picture_status (picture_status),
        .drop           (drop),
        .decoder_lag    (decoder_lag),
        .top_first_in   (top_first_in),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    // Output register is free when empty or drained this cycle
    assign res_take = !out_valid_reg || out_ready;

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_out       = res_reg.frame_out;
    assign whole_picture   = res_reg.whole_picture;
    assign stamp_out       = res_reg.stamp_out;
    assign stamp_out_valid = res_reg.stamp_out_valid;
    assign top_first_out   = res_reg.top_first_out;
    assign overflow        = res_reg.overflow;
    assign no_stamp_error  = res_reg.no_stamp_error;

endmodule

/* verif/testbench.sv */
module testbench;
    import tsrq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes without a package name
    localparam logic                MODE_DECODE  = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDEF = 2'd3;
    localparam logic [OVR_W-1:0]    OVR_KEEP     = 2'd0;
    localparam logic [OVR_W-1:0]    OVR_UNDEF    = 2'd3;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int PHASES      = 7;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic                      mode;
        logic signed [STAMP_W-1:0] stamp;
        logic                      stamp_valid;
        logic [STATUS_W-1:0]       status;
        logic                      drop;
        logic signed [LAG_W-1:0]   lag;
        logic                      top_in;
    } stamp_word_t;

    // Register settings per phase, extremes included
    bit               phase_corr[PHASES] = '{1, 1, 0, 1, 1, 0, 1};
    logic [OVR_W-1:0] phase_ovr[PHASES]  = '{OVR_KEEP, OVR_TOP, OVR_BOTTOM, OVR_BOTTOM,
                                             OVR_UNDEF, OVR_TOP, OVR_KEEP};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      mode = 1'b0;
    logic signed [STAMP_W-1:0] stamp = '0;
    logic                      stamp_valid = 1'b0;
    logic [STATUS_W-1:0]       picture_status = '0;
    logic                      drop = 1'b0;
    logic signed [LAG_W-1:0]   decoder_lag = '0;
    logic                      top_first_in = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      frame_out;
    logic                      whole_picture;
    logic signed [STAMP_W-1:0] stamp_out;
    logic                      stamp_out_valid;
    logic                      top_first_out;
    logic                      overflow;
    logic                      no_stamp_error;
    logic                      cfg_we = 1'b0;
    logic [0:0]                cfg_index = '0;
    logic [OVR_W-1:0]          cfg_data = '0;

    // Shadow of the block state and registers
    logic signed [STAMP_W-1:0] held_stamps[DEPTH];
    int                        held_count = 0;
    bit                        corr_on = 1'b0;
    logic [OVR_W-1:0]          order_ovr = OVR_KEEP;

    stamp_word_t pend_words[$];
    result_t     stamp_results[$];
    stamp_word_t cur_word;

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    timestamp_reorder_queue_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Insert, pop and cut the shadow store for one word
    function automatic result_t reorder_stamp(stamp_word_t w);
        result_t r;
        bit      got_pic;
        int      lag_n;
        int      pos;
        int      k;
        r = '0;
        if (w.mode == MODE_RESYNC)
        begin
            held_count = 0;
            return r;
        end
        got_pic = (w.status != STATUS_PARTIAL);
        r.whole_picture = got_pic;
        lag_n = w.lag;
        if (corr_on && w.stamp_valid && (got_pic || held_count < lag_n))
        begin
            if (held_count >= DEPTH)
                r.overflow = 1'b1;
            else
            begin
                // equal stamps land above the ones already held, nearer the top
                pos = 0;
                while (pos < held_count && held_stamps[pos] >= w.stamp)
                    pos++;
                for (k = held_count; k > pos; k--)
                    held_stamps[k] = held_stamps[k-1];
                held_stamps[pos] = w.stamp;
                held_count++;
            end
        end
        if (w.status == STATUS_COMPLETE && !w.drop)
        begin
            r.frame_out = 1'b1;
            case (order_ovr)
                OVR_TOP:    r.top_first_out = 1'b1;
                OVR_BOTTOM: r.top_first_out = 1'b0;
                default:    r.top_first_out = w.top_in;
            endcase
            if (corr_on)
            begin
                if (held_count > 0)
                begin
                    held_count--;
                    r.stamp_out = held_stamps[held_count];
                    r.stamp_out_valid = 1'b1;
                end
                else
                    r.no_stamp_error = 1'b1;
                if (lag_n >= 0 && lag_n <= held_count)
                    held_count = lag_n;
            end
        end
        return r;
    endfunction

    function automatic stamp_word_t make_word(logic m, logic signed [STAMP_W-1:0] s,
                                              logic sv, logic [STATUS_W-1:0] st,
                                              logic dr, logic signed [LAG_W-1:0] lg,
                                              logic top);
        stamp_word_t w;
        w.mode = m;
        w.stamp = s;
        w.stamp_valid = sv;
        w.status = st;
        w.drop = dr;
        w.lag = lg;
        w.top_in = top;
        return w;
    endfunction

    // Full-range, small (to force ties) or extreme stamps
    function automatic logic signed [STAMP_W-1:0] rand_stamp();
        int small_v;
        case ($urandom_range(0, 5))
            0, 1, 2: return {$urandom, $urandom};
            3, 4:
            begin
                small_v = $urandom_range(0, 16);
                return STAMP_W'(small_v - 8);
            end
            default: return $urandom_range(0, 1) ? 64'sh7FFF_FFFF_FFFF_FFFF
                                                 : 64'sh8000_0000_0000_0000;
        endcase
    endfunction

    // Well-formed decode stream: rising stamps with jitter, fixed lag
    task automatic push_stream(int len);
        logic signed [STAMP_W-1:0] base;
        int                        lag_pick;
        int                        pick;
        int                        i;
        stamp_word_t               w;
        base = {$urandom, $urandom};
        lag_pick = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, 6);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            w.mode = MODE_DECODE;
            w.stamp = base + $urandom_range(0, 4) * 3;
            base = base + 3;
            w.stamp_valid = ($urandom_range(0, 9) != 0);
            w.status = (pick < 80) ? STATUS_COMPLETE : (pick < 90) ? STATUS_PARTIAL : STATUS_NONE;
            w.drop = ($urandom_range(0, 19) == 0);
            w.lag = 9'(lag_pick);
            w.top_in = 1'($urandom_range(0, 1));
            pend_words.push_back(w);
        end
    endtask

    // Stamps with no delivered frame: fill the store up to overflow
    task automatic push_fill(int len);
        int          pick;
        int          i;
        stamp_word_t w;
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 2);
            w.mode = MODE_DECODE;
            w.stamp = rand_stamp();
            w.stamp_valid = 1'b1;
            w.status = (pick == 0) ? STATUS_NONE : (pick == 1) ? STATUS_UNDEF : STATUS_COMPLETE;
            w.drop = (pick == 2) ? 1'b1 : 1'($urandom_range(0, 1));
            w.lag = 9'($urandom_range(0, 511));
            w.top_in = 1'($urandom_range(0, 1));
            pend_words.push_back(w);
        end
    endtask

    task automatic push_random(int n);
        int          added;
        int          pick;
        int          len;
        stamp_word_t w;
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(5, 20);
                push_stream(len);
            end
            else if (pick < 65)
            begin
                len = $urandom_range(30, 40);
                push_fill(len);
            end
            else
            begin
                len = 1;
                w = make_word(pick >= 95 ? MODE_RESYNC : MODE_DECODE, rand_stamp(),
                              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                              1'($urandom_range(0, 1)));
                pend_words.push_back(w);
            end
            added += len;
        end
    endtask

    task automatic write_regs(bit corr, logic [OVR_W-1:0] ovr);
        logic junk_bit;
        junk_bit = 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CORRECTION;
        cfg_data <= {junk_bit, corr};
        corr_on = corr;
        @(posedge clk);
        cfg_index <= CFG_OVERRIDE;
        cfg_data <= ovr;
        order_ovr = ovr;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string field, logic [STAMP_W-1:0] want,
                               logic [STAMP_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: offer pending words, predict on accept
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                stamp_results.push_back(reorder_stamp(cur_word));
            if (in_valid && !in_ready)
            begin
                // hold the word until taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pend_words.size() == 0)
                in_valid <= 1'b0;
            else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            begin
                send_gap = $urandom_range(0, 12);
                in_valid <= 1'b0;
            end
            else
            begin
                cur_word = pend_words.pop_front();
                mode <= cur_word.mode;
                stamp <= cur_word.stamp;
                stamp_valid <= cur_word.stamp_valid;
                picture_status <= cur_word.status;
                drop <= cur_word.drop;
                decoder_lag <= cur_word.lag;
                top_first_in <= cur_word.top_in;
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: compare each result word, stall the output side
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (stamp_results.size() == 0)
                begin
                    $error("result word with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = stamp_results.pop_front();
                    check_field("frame_out", want.frame_out, frame_out);
                    check_field("whole_picture", want.whole_picture, whole_picture);
                    check_field("stamp_out", want.stamp_out, stamp_out);
                    check_field("stamp_out_valid", want.stamp_out_valid, stamp_out_valid);
                    check_field("top_first_out", want.top_first_out, top_first_out);
                    check_field("overflow", want.overflow, overflow);
                    check_field("no_stamp_error", want.no_stamp_error, no_stamp_error);
                end
                // long hold-off so the block backs up into its input
                if (results_seen % 300 == 150)
                    hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_gap = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = (ph == PHASES - 1) ? 0 : 25 * $urandom_range(0, 2);
            recv_idle_pct = (ph == PHASES - 1) ? 0 : 25 * $urandom_range(0, 2);
            write_regs(phase_corr[ph], phase_ovr[ph]);
            if (ph == 0)
            begin
                // extremes of the stamp
                pend_words.push_back(make_word(MODE_DECODE, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1,
                                               STATUS_COMPLETE, 1'b0, -9'sd1, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, 64'sh8000_0000_0000_0000, 1'b1,
                                               STATUS_COMPLETE, 1'b0, -9'sd1, 1'b0));
                // delivery from an empty store
                pend_words.push_back(make_word(MODE_DECODE, 64'sd0, 1'b0,
                                               STATUS_COMPLETE, 1'b0, -9'sd1, 1'b1));
                // no image, equal stamps, negative stamp
                pend_words.push_back(make_word(MODE_DECODE, 64'sd5, 1'b1,
                                               STATUS_NONE, 1'b0, -9'sd1, 1'b0));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd5, 1'b1,
                                               STATUS_NONE, 1'b0, -9'sd1, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, -64'sd3, 1'b1,
                                               STATUS_NONE, 1'b0, -9'sd1, 1'b0));
                // incomplete image: inserted below the lag, never with unknown lag
                pend_words.push_back(make_word(MODE_DECODE, 64'sd9, 1'b1,
                                               STATUS_PARTIAL, 1'b0, 9'sd255, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd10, 1'b1,
                                               STATUS_PARTIAL, 1'b0, -9'sd1, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd11, 1'b1,
                                               STATUS_PARTIAL, 1'b0, 9'h100, 1'b0));
                // undefined status acts as no image
                pend_words.push_back(make_word(MODE_DECODE, 64'sd12, 1'b1,
                                               STATUS_UNDEF, 1'b0, 9'sd0, 1'b1));
                // dropped frame keeps its stamp
                pend_words.push_back(make_word(MODE_DECODE, 64'sd0, 1'b1,
                                               STATUS_COMPLETE, 1'b1, 9'sd0, 1'b1));
                // pop then cut the count to the lag
                pend_words.push_back(make_word(MODE_DECODE, 64'sd0, 1'b0,
                                               STATUS_COMPLETE, 1'b0, 9'sd2, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd7, 1'b1,
                                               STATUS_COMPLETE, 1'b0, 9'sd0, 1'b0));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd0, 1'b0,
                                               STATUS_COMPLETE, 1'b0, -9'sd1, 1'b1));
                // resync with junk in every field
                pend_words.push_back(make_word(MODE_RESYNC, -64'sd1, 1'b1,
                                               STATUS_COMPLETE, 1'b0, 9'sd255, 1'b1));
                pend_words.push_back(make_word(MODE_DECODE, 64'sd1, 1'b1,
                                               STATUS_COMPLETE, 1'b0, 9'sd255, 1'b1));
                push_fill(40);
            end
            push_random(90);
            // drain before touching the registers again
            while (pend_words.size() != 0 || in_valid || stamp_results.size() != 0)
                @(negedge clk);
        end
        repeat (DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0 && stamp_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
